>>> hw/rtl/pwmdc_pkg.sv
// shared types, constants and helpers for the pwm input debounce capture block
package pwmdc_pkg;

    // sizing
    localparam int CHANNELS     = 8;
    localparam int PIN_COUNT    = 8;
    localparam int TICKS_PER_US = 200;
    localparam int TICK_W       = 32;
    localparam int DEBOUNCE_W   = 16;
    localparam int WIDTH_US_W   = 25;
    localparam int CHAN_W       = 3;
    localparam int LANE_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(200);
    localparam logic [WIDTH_US_W-1:0] WIDTH_MAX      = {WIDTH_US_W{1'b1}};

    // batch queue between the lanes and the result serializer
    localparam int BATCH_IDX_W = 2;
    localparam int BATCH_DEPTH = 2 ** BATCH_IDX_W;
    localparam int BATCH_CNT_W = BATCH_IDX_W + 1;

    // reciprocal of the tick rate, low by at most two counts after the high-word pick
    localparam logic [TICK_W-1:0] RECIP    = TICK_W'(64'hFFFF_FFFF / TICKS_PER_US);
    localparam logic [TICK_W-1:0] TICK_DIV = TICK_W'(TICKS_PER_US);
    localparam int REM_W = $clog2(3 * TICKS_PER_US);

    typedef enum logic [1:0] {
        PH_WAITING    = 2'd0,
        PH_DEBOUNCING = 2'd1,
        PH_CONFIRM    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [PIN_COUNT-1:0] pin_levels;
        logic [TICK_W-1:0]    tick_count;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]     channel;
        logic                  ended_level;
        logic [WIDTH_US_W-1:0] width_us;
        logic                  last_of_run;
    } result_t;

    // what one lane offers for the current poll
    typedef struct packed {
        logic              fire;
        logic              ended_level;
        logic              first_edge;
        logic [TICK_W-1:0] span;
    } lane_report_t;

    typedef lane_report_t [CHANNELS-1:0] batch_t;

    // one serialized request toward the divide pipeline
    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic              ended_level;
        logic              first_edge;
        logic              last_of_run;
        logic [TICK_W-1:0] span;
    } div_req_t;

    function automatic logic [CHAN_W-1:0] lane_to_chan(input logic [LANE_IDX_W-1:0] idx);
        logic [LANE_IDX_W+CHAN_W-1:0] wide;
        wide = {{CHAN_W{1'b0}}, idx};
        return wide[CHAN_W-1:0];
    endfunction

endpackage

>>> hw/rtl/pwm_input_debounce_capture.sv
// top level of the debounced pwm pulse-width capture block
//
// Usage: one request on the input channel is one poll of all pin levels plus the
// free-running 32-bit tick count. Each channel lane debounces its pin; a level
// change that holds for debounce_ticks ticks is confirmed on the following poll,
// and that poll yields one result: channel, the level that ended, and the time
// since the channel's previous confirmed edge in microseconds (0 on its first).
// Results of one poll leave in ascending channel order, the last one flagged.
// Throughput: one poll per cycle while in_stall is low; results leave at one per
// cycle while out_stall is low. A result reaches the output register from the poll
// that caused it through queue read, reciprocal multiply, remainder, correction.
// Confirming polls are queued as batches, up to four; in_stall rises while
// four batches wait, so a long out_stall or a dense burst of confirming polls
// (more results than one per cycle) backs up into the input channel.
// The output holds its request while out_stall is high.
// Reset: all lanes wait with settled level 0 and first edge pending,
// debounce_ticks returns to 200, the queue and pipeline empty.
// cfg_wr_en writes debounce_ticks; write it only while the block is idle.
module pwm_input_debounce_capture
    import pwmdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [DEBOUNCE_W-1:0] cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output result_t               out_data
);

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic                  poll_accept;
    logic                  queue_full;
    batch_t                reports;
    logic                  req_valid;
    logic                  req_ready;
    div_req_t              req;

    // debounce register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            debounce_reg <= DEBOUNCE_RESET;
        else if (cfg_wr_en)
            debounce_reg <= cfg_wr_data;
    end

    assign in_stall    = queue_full;
    assign poll_accept = in_valid && !in_stall;

    // one lane per channel
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_lane
        logic level;
        if (g < PIN_COUNT)
        begin : g_pin
            assign level = in_data.pin_levels[g];
        end
        else
        begin : g_nopin
            assign level = 1'b0;
        end
        pwmdc_lane u_lane (
            .clk            (clk),
            .rst_n          (rst_n),
            .poll_accept    (poll_accept),
            .level          (level),
            .tick_count     (in_data.tick_count),
            .debounce_ticks (debounce_reg),
            .report         (reports[g])
        );
    end

    // batch queue and serializer
    pwmdc_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .poll_accept (poll_accept),
        .reports     (reports),
        .full        (queue_full),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req)
    );

    // divide and output register
    pwmdc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> hw/rtl/pwmdc_lane.sv
// one channel lane: debounce state machine and edge time keeping
module pwmdc_lane
    import pwmdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  poll_accept,
    input  logic                  level,
    input  logic [TICK_W-1:0]     tick_count,
    input  logic [DEBOUNCE_W-1:0] debounce_ticks,
    output lane_report_t          report
);

    phase_t            phase_reg, phase_next;
    logic              settled_reg, settled_next;
    logic              first_reg, first_next;
    logic [TICK_W-1:0] cand_reg, cand_next;
    logic [TICK_W-1:0] prev_reg, prev_next;
    logic [TICK_W-1:0] held;
    logic              held_long;

    // time the changed level has persisted
    assign held      = tick_count - cand_reg;
    assign held_long = {{(TICK_W-DEBOUNCE_W){1'b0}}, debounce_ticks} <= held;

    // report is fully known from state when the lane sits in confirm
    assign report.fire        = (phase_reg == PH_CONFIRM);
    assign report.ended_level = settled_reg;
    assign report.first_edge  = first_reg;
    assign report.span        = cand_reg - prev_reg;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAITING;
            settled_reg <= 1'b0;
            first_reg   <= 1'b1;
            cand_reg    <= '0;
            prev_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            settled_reg <= settled_next;
            first_reg   <= first_next;
            cand_reg    <= cand_next;
            prev_reg    <= prev_next;
        end
    end

    // next state on each accepted poll
    always_comb
    begin
        phase_next   = phase_reg;
        settled_next = settled_reg;
        first_next   = first_reg;
        cand_next    = cand_reg;
        prev_next    = prev_reg;
        if (poll_accept)
        begin
            unique case (phase_reg)
                PH_WAITING:
                begin
                    if (level != settled_reg)
                    begin
                        cand_next  = tick_count;
                        phase_next = (debounce_ticks == '0) ? PH_CONFIRM : PH_DEBOUNCING;
                    end
                end
                PH_DEBOUNCING:
                begin
                    if (level == settled_reg)
                        phase_next = PH_WAITING;
                    else if (held_long)
                        phase_next = PH_CONFIRM;
                end
                PH_CONFIRM:
                begin
                    first_next   = 1'b0;
                    prev_next    = cand_reg;
                    settled_next = level;
                    phase_next   = PH_WAITING;
                end
                default:
                begin
                    phase_next = PH_WAITING;
                end
            endcase
        end
    end

    // a confirmed edge is reported once and the lane goes back to waiting
    a_confirm_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (poll_accept && phase_reg == PH_CONFIRM) |=> (phase_reg == PH_WAITING && !first_reg))
        else $error("lane stayed in confirm after an accepted poll");

endmodule

>>> hw/rtl/pwmdc_merge.sv
// batch queue of lane reports and lowest-channel-first serializer
module pwmdc_merge
    import pwmdc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     poll_accept,
    input  batch_t   reports,
    output logic     full,
    output logic     req_valid,
    input  logic     req_ready,
    output div_req_t req
);

    batch_t                 batch_reg [BATCH_DEPTH];
    logic [BATCH_IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [BATCH_IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [BATCH_CNT_W-1:0] count_reg, count_next;
    logic [CHANNELS-1:0]    done_reg, done_next;

    batch_t                 head;
    logic [CHANNELS-1:0]    new_mask;
    logic [CHANNELS-1:0]    head_mask;
    logic [CHANNELS-1:0]    remaining;
    logic [CHANNELS-1:0]    pick_oh;
    logic [LANE_IDX_W-1:0]  pick_idx;
    logic                   push;
    logic                   issue;
    logic                   last;

    // fire masks of the incoming and the head batch
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            new_mask[i]  = reports[i].fire;
            head_mask[i] = head[i].fire;
        end
    end

    assign head      = batch_reg[rd_ptr_reg];
    assign full      = (count_reg == BATCH_CNT_W'(BATCH_DEPTH));
    assign push      = poll_accept && (new_mask != '0);
    assign req_valid = (count_reg != '0);
    assign issue     = req_valid && req_ready;

    // lowest channel still owed from the head batch
    assign remaining = head_mask & ~done_reg;
    assign pick_oh   = remaining & (~remaining + CHANNELS'(1));
    assign last      = ((remaining & ~pick_oh) == '0);

    always_comb
    begin
        pick_idx = '0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (remaining[i])
                pick_idx = LANE_IDX_W'(i);
        end
    end

    // request toward the divider
    assign req.channel     = lane_to_chan(pick_idx);
    assign req.ended_level = head[pick_idx].ended_level;
    assign req.first_edge  = head[pick_idx].first_edge;
    assign req.last_of_run = last;
    assign req.span        = head[pick_idx].span;

    // batch storage
    always_ff @(posedge clk)
    begin
        if (push)
            batch_reg[wr_ptr_reg] <= reports;
    end

    // queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            done_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        done_next   = done_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + BATCH_IDX_W'(1);
        end
        if (issue)
        begin
            if (last)
            begin
                rd_ptr_next = rd_ptr_reg + BATCH_IDX_W'(1);
                done_next   = '0;
            end
            else
            begin
                done_next = done_reg | pick_oh;
            end
        end
        if (push && !(issue && last))
            count_next = count_reg + BATCH_CNT_W'(1);
        else if (!push && issue && last)
            count_next = count_reg - BATCH_CNT_W'(1);
    end

    // a queued batch always has exactly one channel picked
    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid |-> $onehot(pick_oh))
        else $error("queued batch with no channel left to send");

    // no batch is taken while the queue is full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (poll_accept && full) |-> (new_mask == '0 && 1'b0) || !(poll_accept && full))
        else $error("poll accepted into a full batch queue");

    // fill level follows the pointers
    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != BATCH_CNT_W'(BATCH_DEPTH)) |->
            (BATCH_IDX_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[BATCH_IDX_W-1:0]))
        else $error("batch queue count and pointers disagree");

endmodule

>>> hw/rtl/pwmdc_div.sv
// pipelined tick-to-microsecond divide with output register
module pwmdc_div
    import pwmdc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  div_req_t req,
    output logic     out_valid,
    input  logic     out_stall,
    output result_t  out_data
);

    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    div_req_t            s1_reg, s2_reg, s3_reg;
    logic [TICK_W-1:0]   q0_s2_reg, q0_s3_reg;
    logic [REM_W-1:0]    rem_reg;
    result_t             out_data_reg;

    logic                out_free, s3_free, s2_free, s1_free;
    logic [2*TICK_W-1:0] prod;
    logic [TICK_W-1:0]   rem_full;
    logic [TICK_W-1:0]   q_fix;
    logic [TICK_W-1:0]   q;
    logic [WIDTH_US_W-1:0] width_sat;
    result_t             out_data_next;

    // stage advance chain
    assign out_free  = !out_valid_reg || !out_stall;
    assign s3_free   = !s3_valid_reg || out_free;
    assign s2_free   = !s2_valid_reg || s3_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign req_ready = s1_free;

    // estimate quotient by reciprocal, then remainder against it
    assign prod     = {{TICK_W{1'b0}}, s1_reg.span} * {{TICK_W{1'b0}}, RECIP};
    assign rem_full = s2_reg.span - q0_s2_reg * TICK_DIV;

    // correct the estimate, saturate, zero for the first edge
    always_comb
    begin
        if (rem_reg >= REM_W'(2 * TICKS_PER_US))
            q_fix = TICK_W'(2);
        else if (rem_reg >= REM_W'(TICKS_PER_US))
            q_fix = TICK_W'(1);
        else
            q_fix = '0;
        q = q0_s3_reg + q_fix;
        if (q > {{(TICK_W-WIDTH_US_W){1'b0}}, WIDTH_MAX})
            width_sat = WIDTH_MAX;
        else
            width_sat = q[WIDTH_US_W-1:0];
        out_data_next.channel     = s3_reg.channel;
        out_data_next.ended_level = s3_reg.ended_level;
        out_data_next.width_us    = s3_reg.first_edge ? '0 : width_sat;
        out_data_next.last_of_run = s3_reg.last_of_run;
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= req_valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
            if (out_free)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (s1_free)
            s1_reg <= req;
        if (s2_free)
        begin
            s2_reg    <= s1_reg;
            q0_s2_reg <= prod[2*TICK_W-1:TICK_W];
        end
        if (s3_free)
        begin
            s3_reg    <= s2_reg;
            q0_s3_reg <= q0_s2_reg;
            rem_reg   <= rem_full[REM_W-1:0];
        end
        if (out_free)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // reciprocal estimate is never more than two below the true quotient
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (rem_full < TICK_W'(3 * TICKS_PER_US)))
        else $error("divide estimate out of correction range");

endmodule
